FILE: hw/rtl/mqttdf_pkg.sv
// Shared types, codes and topic tables of the MQTT publish deframer.
package mqttdf_pkg;

  // Result kinds
  localparam logic [1:0] KIND_FRAME     = 2'd0;
  localparam logic [1:0] KIND_SUBSCRIBE = 2'd1;
  localparam logic [1:0] KIND_RESET     = 2'd2;
  localparam logic [1:0] KIND_DROP      = 2'd3;

  // Packet type field (high nibble of byte 0)
  localparam logic [3:0] TYPE_CONNACK = 4'h2;
  localparam logic [3:0] TYPE_PUBLISH = 4'h3;

  // Topic positions inside the packet
  localparam logic [8:0] POS_TYPE     = 9'd0;
  localparam logic [8:0] POS_LEN      = 9'd1;
  localparam logic [8:0] POS_XRF_LO   = 9'd4;
  localparam logic [8:0] POS_XRF_HI   = 9'd8;
  localparam logic [8:0] POS_DEV_HI   = 9'd9;
  localparam logic [8:0] POS_DEV_LO   = 9'd10;
  localparam logic [8:0] POS_PKT_LO   = 9'd11;
  localparam logic [8:0] POS_PKT_HI   = 9'd14;
  localparam logic [8:0] POS_RST_HI   = 9'd17;
  localparam logic [8:0] POS_PAYLOAD  = 9'd15;
  localparam logic [8:0] LEN_XRF_MIN  = 9'd15;
  localparam logic [8:0] LEN_RST_MIN  = 9'd18;
  localparam logic [8:0] LEN_HDR      = 9'd14;

  // Output register load selector
  typedef enum logic [2:0] {
    SEL_DROP,
    SEL_SUB,
    SEL_RST,
    SEL_LEN,
    SEL_DEV,
    SEL_MEM
  } sel_e;

  // Controller to datapath
  typedef struct packed {
    logic rx_take;
    logic load_out;
    sel_e out_sel;
    logic ptr_init;
    logic ptr_inc;
    logic rd_en;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pkt_end;
    logic out_free;
    logic big;
    logic connack;
    logic publish;
    logic xrf_hit;
    logic frame_bad;
    logic rst_hit;
    logic len_min;
    logic ptr_last;
  } stat_t;

  // "/xrf/"
  function automatic logic [7:0] xrf_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2F;
      3'd1:    c = 8'h78;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h66;
      default: c = 8'h2F;
    endcase
    return c;
  endfunction

  // "/pkt"
  function automatic logic [7:0] pkt_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h2F;
      2'd1:    c = 8'h70;
      2'd2:    c = 8'h6B;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // Broker reset topic, 14 characters
  function automatic logic [7:0] rst_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2F;
      4'd1:    c = 8'h6D;
      4'd2:    c = 8'h71;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h68;
      4'd6:    c = 8'h75;
      4'd7:    c = 8'h62;
      4'd8:    c = 8'h2F;
      4'd9:    c = 8'h72;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h73;
      4'd12:   c = 8'h65;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // Wrapping hex digit, no validity check
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else begin
      v = c + 8'h0A - 8'h41;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/mqttdf_ctrl.sv
// Sequencing state machine of the MQTT publish deframer.
module mqttdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mqttdf_pkg::stat_t  stat_i,
  output mqttdf_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] ST_RECV   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_LEN    = 3'd2;
  localparam logic [2:0] ST_DEV    = 3'd3;
  localparam logic [2:0] ST_RDREQ  = 3'd4;
  localparam logic [2:0] ST_RDLOAD = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.out_sel  = mqttdf_pkg::SEL_DROP;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_RECV: begin
        in_ready_o    = 1'b1;
        cmd_o.rx_take = in_valid_i;
        if (in_valid_i && stat_i.pkt_end) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.big) begin
          cmd_o.out_sel = mqttdf_pkg::SEL_DROP;
          if (stat_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_RECV;
          end
        end else if (stat_i.connack) begin
          cmd_o.out_sel = mqttdf_pkg::SEL_SUB;
          if (stat_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_RECV;
          end
        end else if (!stat_i.publish) begin
          state_d = ST_RECV;
        end else if (stat_i.xrf_hit) begin
          if (stat_i.frame_bad) begin
            cmd_o.out_sel = mqttdf_pkg::SEL_DROP;
            if (stat_i.out_free) begin
              cmd_o.load_out = 1'b1;
              state_d        = ST_RECV;
            end
          end else begin
            cmd_o.ptr_init = 1'b1;
            state_d        = ST_LEN;
          end
        end else if (stat_i.rst_hit) begin
          cmd_o.out_sel = mqttdf_pkg::SEL_RST;
          if (stat_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_RECV;
          end
        end else begin
          state_d = ST_RECV;
        end
      end
      ST_LEN: begin
        cmd_o.out_sel = mqttdf_pkg::SEL_LEN;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd_o.out_sel = mqttdf_pkg::SEL_DEV;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = stat_i.len_min ? ST_RECV : ST_RDREQ;
        end
      end
      ST_RDREQ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_RDLOAD;
      end
      ST_RDLOAD: begin
        cmd_o.out_sel = mqttdf_pkg::SEL_MEM;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
          state_d        = stat_i.ptr_last ? ST_RECV : ST_RDREQ;
        end
      end
      default: begin
        state_d = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/mqttdf_dp.sv
// Datapath of the MQTT publish deframer: byte store, header flags, output register.
module mqttdf_dp #(
  parameter int PACKET_DEPTH = 128,
  parameter int FRAME_MAX    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_byte_i,
  input  mqttdf_pkg::cmd_t  cmd_i,
  output mqttdf_pkg::stat_t stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        frame_byte_o,
  output logic              frame_last_o
);

  localparam int         AW        = $clog2(PACKET_DEPTH);
  localparam logic [9:0] DEPTH_LIM = 10'(PACKET_DEPTH);
  localparam logic [9:0] FRAME_LIM = 10'(FRAME_MAX + 13);

  logic [7:0] mem [PACKET_DEPTH];

  logic [8:0] cnt_q, cnt_d;
  logic [7:0] len_q;
  logic [3:0] type_q;
  logic [7:0] hi_q, lo_q;
  logic       xrf_miss_q, rst_miss_q;
  logic [8:0] ptr_q;
  logic [7:0] rd_data_q;

  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic [8:0] cnt_nx, plen, plen_now, pos_m4, pos_m11;
  logic       in_xrf, in_pkt, in_rst;
  logic [7:0] dev_hi, dev_lo, dev_byte;

  assign cnt_nx   = cnt_q + 9'd1;
  assign plen     = {1'b0, len_q} + 9'd2;
  assign plen_now = (cnt_q == mqttdf_pkg::POS_LEN) ? ({1'b0, rx_byte_i} + 9'd2) : plen;
  assign pos_m4   = cnt_q - mqttdf_pkg::POS_XRF_LO;
  assign pos_m11  = cnt_q - mqttdf_pkg::POS_PKT_LO;
  assign in_xrf   = cnt_q >= mqttdf_pkg::POS_XRF_LO && cnt_q <= mqttdf_pkg::POS_XRF_HI;
  assign in_pkt   = cnt_q >= mqttdf_pkg::POS_PKT_LO && cnt_q <= mqttdf_pkg::POS_PKT_HI;
  assign in_rst   = cnt_q >= mqttdf_pkg::POS_XRF_LO && cnt_q <= mqttdf_pkg::POS_RST_HI;

  assign dev_hi   = mqttdf_pkg::hex_digit(hi_q);
  assign dev_lo   = mqttdf_pkg::hex_digit(lo_q);
  assign dev_byte = {dev_hi[3:0], 4'h0} | dev_lo;

  always_comb begin
    stat_o           = '0;
    stat_o.pkt_end   = cnt_nx >= 9'd2 && cnt_nx >= plen_now;
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.big       = {1'b0, plen} > DEPTH_LIM;
    stat_o.connack   = type_q == mqttdf_pkg::TYPE_CONNACK;
    stat_o.publish   = type_q == mqttdf_pkg::TYPE_PUBLISH;
    stat_o.xrf_hit   = !xrf_miss_q && plen >= mqttdf_pkg::LEN_XRF_MIN;
    stat_o.frame_bad = {1'b0, plen} > FRAME_LIM;
    stat_o.rst_hit   = !rst_miss_q && plen >= mqttdf_pkg::LEN_RST_MIN;
    stat_o.len_min   = plen == mqttdf_pkg::LEN_XRF_MIN;
    stat_o.ptr_last  = (ptr_q + 9'd1) == plen;
  end

  assign cnt_d = stat_o.pkt_end ? 9'd0 : cnt_nx;

  // Byte count and header capture; topic compare runs as bytes arrive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.rx_take) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take) begin
      if (cnt_q == mqttdf_pkg::POS_TYPE) begin
        type_q     <= rx_byte_i[7:4];
        xrf_miss_q <= 1'b0;
        rst_miss_q <= 1'b0;
      end
      if (cnt_q == mqttdf_pkg::POS_LEN) begin
        len_q <= rx_byte_i;
      end
      if (cnt_q == mqttdf_pkg::POS_DEV_HI) begin
        hi_q <= rx_byte_i;
      end
      if (cnt_q == mqttdf_pkg::POS_DEV_LO) begin
        lo_q <= rx_byte_i;
      end
      if ((in_xrf && rx_byte_i != mqttdf_pkg::xrf_char(pos_m4[2:0])) ||
          (in_pkt && rx_byte_i != mqttdf_pkg::pkt_char(pos_m11[1:0]))) begin
        xrf_miss_q <= 1'b1;
      end
      if (in_rst && rx_byte_i != mqttdf_pkg::rst_char(pos_m4[3:0])) begin
        rst_miss_q <= 1'b1;
      end
    end
    if (cmd_i.ptr_init) begin
      ptr_q <= mqttdf_pkg::POS_PAYLOAD;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + 9'd1;
    end
  end

  // Byte store
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take && {1'b0, cnt_q} < DEPTH_LIM) begin
      mem[cnt_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[ptr_q[AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.out_sel)
        mqttdf_pkg::SEL_SUB: begin
          kind_q <= mqttdf_pkg::KIND_SUBSCRIBE;
          byte_q <= 8'h00;
          last_q <= 1'b1;
        end
        mqttdf_pkg::SEL_RST: begin
          kind_q <= mqttdf_pkg::KIND_RESET;
          byte_q <= 8'h00;
          last_q <= 1'b1;
        end
        mqttdf_pkg::SEL_LEN: begin
          kind_q <= mqttdf_pkg::KIND_FRAME;
          byte_q <= 8'(plen - mqttdf_pkg::LEN_HDR);
          last_q <= 1'b0;
        end
        mqttdf_pkg::SEL_DEV: begin
          kind_q <= mqttdf_pkg::KIND_FRAME;
          byte_q <= dev_byte;
          last_q <= stat_o.len_min;
        end
        mqttdf_pkg::SEL_MEM: begin
          kind_q <= mqttdf_pkg::KIND_FRAME;
          byte_q <= rd_data_q;
          last_q <= stat_o.ptr_last;
        end
        default: begin
          kind_q <= mqttdf_pkg::KIND_DROP;
          byte_q <= 8'h00;
          last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign frame_byte_o  = byte_q;
  assign frame_last_o  = last_q;

endmodule

FILE: hw/rtl/mqtt_publish_to_radio_deframer.sv
// Top level of the MQTT receive deframer that feeds the radio transmitter.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | rx_byte_i
//  out     | source    | out_valid_o/out_ready_i | result_kind_o, frame_byte_o, frame_last_o
//
// Receive takes one byte per cycle while in_ready_o is high; the packet store
// write port sets that. After the last byte of a packet, a decision state loads
// a single result or none; a frame goes on with its length and device beats,
// then a store read and a load into the output register for each payload
// byte; out_ready_i low stretches each load.
// A new packet's bytes are taken while the packet's final beat still waits.
// Reset clears the byte count, the output valid and the controller state only; the store needs no
// clearing pass, since every entry read was written earlier in the packet.
module mqtt_publish_to_radio_deframer #(
  parameter int PACKET_DEPTH = 128,
  parameter int FRAME_MAX    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  mqttdf_pkg::cmd_t  cmd;
  mqttdf_pkg::stat_t stat;

  // Controller: receive, decide at packet end, sequence the frame beats
  mqttdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: store, on-the-fly topic match, device id, output register
  mqttdf_dp #(
    .PACKET_DEPTH (PACKET_DEPTH),
    .FRAME_MAX    (FRAME_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o)
  );

`ifndef ASSERT_OFF
  // A pending beat is never overwritten
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("output register loaded while a beat is pending");

  // No result is produced while bytes are being received
  a_recv_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.load_out && !cmd.rd_en)
    else $error("result sequencing during receive");

  // Non-frame results are single, closing beats with a zero byte
  a_ctrl_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != mqttdf_pkg::KIND_FRAME
      |-> frame_byte_o == 8'h00 && frame_last_o)
    else $error("malformed control result");
`endif

endmodule
